[rtl/acr_pkg.sv]
// Package for the box collision resolver: widths, register indexes, codes,
// item and result types, and the controller/datapath command and status.
// No dependencies.
package acr_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_BOXES_DEF = 64;
    localparam int PASSES_DEF    = 3;

    // Field widths
    localparam int COORD_W    = 24;
    localparam int HALF_W     = 23;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    // Penetration depth and pushed coordinate widths
    localparam int DEP_W      = 26;
    localparam int SUM_W      = DEP_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_FLOOR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESPAWN_Y    = 2'd2;

    // Register reset values
    localparam logic [COUNT_W-1:0]        BOX_COUNT_RST    = 7'd0;
    localparam logic signed [COORD_W-1:0] KILL_FLOOR_Y_RST = -24'sd3200;
    localparam logic signed [COORD_W-1:0] RESPAWN_Y_RST    = 24'sd576;

    // Item commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Wall normal codes
    localparam logic [1:0] WALL_POS_X = 2'd0;
    localparam logic [1:0] WALL_NEG_X = 2'd1;
    localparam logic [1:0] WALL_POS_Z = 2'd2;
    localparam logic [1:0] WALL_NEG_Z = 2'd3;

    // Coordinate limits
    localparam logic signed [COORD_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] POS_MIN = -24'sh800000;

    typedef struct packed {
        logic                        cmd;
        logic [SLOT_W-1:0]           box_slot;
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic signed [COORD_W-1:0]   pos_z;
        logic [HALF_W-1:0]           ext_x;
        logic [HALF_W-1:0]           ext_y;
        logic [HALF_W-1:0]           ext_z;
        logic signed [COORD_W-1:0]   vel_x;
        logic signed [COORD_W-1:0]   vel_y;
        logic signed [COORD_W-1:0]   vel_z;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   res_x;
        logic signed [COORD_W-1:0]   res_y;
        logic signed [COORD_W-1:0]   res_z;
        logic signed [COORD_W-1:0]   new_vel_x;
        logic signed [COORD_W-1:0]   new_vel_y;
        logic signed [COORD_W-1:0]   new_vel_z;
        logic                        on_ground;
        logic                        on_wall;
        logic [1:0]                  wall_dir;
        logic                        respawned;
    } result_t;

    // One world box entry of the table
    typedef struct packed {
        logic signed [COORD_W-1:0]   cx;
        logic signed [COORD_W-1:0]   cy;
        logic signed [COORD_W-1:0]   cz;
        logic [HALF_W-1:0]           hx;
        logic [HALF_W-1:0]           hy;
        logic [HALF_W-1:0]           hz;
    } box_t;

    // Controller to datapath
    typedef struct packed {
        logic take;      // item accepted this cycle
        logic depth_en;  // register penetration depths of the current box
        logic push_en;   // apply push-out for the current box
        logic out_load;  // load the output register
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic               is_load;    // offered item is a table load
        logic [COUNT_W-1:0] box_count;  // configured box count
    } stat_t;

endpackage

[rtl/acr_if.sv]
// Valid/ready channel interfaces for the box collision resolver items.
// Depends on acr_pkg for field widths.
interface acr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic [acr_pkg::SLOT_W-1:0]            box_slot;
    logic signed [acr_pkg::COORD_W-1:0]    pos_x;
    logic signed [acr_pkg::COORD_W-1:0]    pos_y;
    logic signed [acr_pkg::COORD_W-1:0]    pos_z;
    logic [acr_pkg::HALF_W-1:0]            ext_x;
    logic [acr_pkg::HALF_W-1:0]            ext_y;
    logic [acr_pkg::HALF_W-1:0]            ext_z;
    logic signed [acr_pkg::COORD_W-1:0]    vel_x;
    logic signed [acr_pkg::COORD_W-1:0]    vel_y;
    logic signed [acr_pkg::COORD_W-1:0]    vel_z;

    modport source (
        output valid, cmd, box_slot, pos_x, pos_y, pos_z,
               ext_x, ext_y, ext_z, vel_x, vel_y, vel_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, box_slot, pos_x, pos_y, pos_z,
               ext_x, ext_y, ext_z, vel_x, vel_y, vel_z,
        output ready
    );
endinterface

interface acr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [acr_pkg::COORD_W-1:0]    res_x;
    logic signed [acr_pkg::COORD_W-1:0]    res_y;
    logic signed [acr_pkg::COORD_W-1:0]    res_z;
    logic signed [acr_pkg::COORD_W-1:0]    new_vel_x;
    logic signed [acr_pkg::COORD_W-1:0]    new_vel_y;
    logic signed [acr_pkg::COORD_W-1:0]    new_vel_z;
    logic                                  on_ground;
    logic                                  on_wall;
    logic [1:0]                            wall_dir;
    logic                                  respawned;

    modport source (
        output valid, res_x, res_y, res_z, new_vel_x, new_vel_y, new_vel_z,
               on_ground, on_wall, wall_dir, respawned,
        input  ready
    );
    modport sink (
        input  valid, res_x, res_y, res_z, new_vel_x, new_vel_y, new_vel_z,
               on_ground, on_wall, wall_dir, respawned,
        output ready
    );
endinterface

[rtl/acr_ctrl.sv]
// Sequencer for the box collision resolver: walks boxes and passes,
// drives the input and output handshakes. Depends on acr_pkg.
module acr_ctrl #(
    parameter int MAX_BOXES = acr_pkg::MAX_BOXES_DEF,
    parameter int PASSES    = acr_pkg::PASSES_DEF,
    localparam int IDX_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  acr_pkg::stat_t     stat,
    output acr_pkg::ctl_t      ctl,
    output logic [IDX_W-1:0]   rd_addr
);

    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int CMP_W  = (IDX_W + 1 > acr_pkg::COUNT_W) ? IDX_W + 1 : acr_pkg::COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEPTH,
        ST_PUSH,
        ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [PASS_W-1:0]            pass_reg, pass_next;
    logic                         out_valid_reg, out_valid_next;
    logic [acr_pkg::COUNT_W-1:0]  n_eff;
    logic                         box_last;
    logic                         pass_last;

    // Clamp the box count to the table size
    always_comb
    begin
        if (int'(stat.box_count) > MAX_BOXES)
            n_eff = acr_pkg::COUNT_W'(MAX_BOXES);
        else
            n_eff = stat.box_count;
    end

    assign box_last  = (CMP_W'(idx_reg) + CMP_W'(1)) == CMP_W'(n_eff);
    assign pass_last = pass_reg == PASS_W'(PASSES - 1);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.take  = 1'b1;
                    idx_next  = '0;
                    pass_next = '0;
                    if (stat.is_load || n_eff == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_DEPTH;
                end
            end
            ST_DEPTH:
            begin
                ctl.depth_en = 1'b1;
                state_next   = ST_PUSH;
            end
            ST_PUSH:
            begin
                ctl.push_en = 1'b1;
                state_next  = ST_DEPTH;
                if (box_last)
                begin
                    idx_next = '0;
                    if (pass_last)
                        state_next = ST_DONE;
                    else
                        pass_next = pass_reg + PASS_W'(1);
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                // Hand over once the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // Present the next box index so its entry is registered on entry to depth
    assign rd_addr   = idx_next;

`ifndef SYNTHESIS
    a_push_after_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> $past(state_reg) == ST_DEPTH)
        else $error("push without a preceding depth step");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DEPTH |-> CMP_W'(idx_reg) < CMP_W'(n_eff))
        else $error("box index beyond the active count");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register loaded while a result waits");
`endif

endmodule

[rtl/acr_dp.sv]
// Datapath for the box collision resolver: box table, config registers,
// player state, penetration and push-out logic, output register. Depends on acr_pkg.
module acr_dp #(
    parameter int MAX_BOXES = acr_pkg::MAX_BOXES_DEF,
    localparam int IDX_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [acr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [acr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  acr_pkg::item_t                       item,
    input  acr_pkg::ctl_t                        ctl,
    input  logic [IDX_W-1:0]                     rd_addr,
    output acr_pkg::stat_t                       stat,
    output acr_pkg::result_t                     result
);

    localparam int CW = acr_pkg::COORD_W;
    localparam int HW = acr_pkg::HALF_W;
    localparam int DW = acr_pkg::DEP_W;
    localparam int SW = acr_pkg::SUM_W;

    // Configuration
    logic [acr_pkg::COUNT_W-1:0]  box_count_reg;
    logic signed [CW-1:0]         kill_floor_reg;
    logic signed [CW-1:0]         respawn_reg;

    // Box table
    acr_pkg::box_t                box_mem [MAX_BOXES];
    acr_pkg::box_t                rd_box_reg;
    logic                         slot_ok;
    logic [IDX_W-1:0]             slot_idx;

    // Player state, one entry per axis
    logic signed [CW-1:0]         p_reg [3];
    logic signed [CW-1:0]         p_next [3];
    logic [HW-1:0]                h_reg [3];
    logic signed [CW-1:0]         v_reg [3];
    logic signed [CW-1:0]         v_next [3];
    logic signed [DW-1:0]         depth_reg [3];
    logic signed [DW-1:0]         depth_c [3];
    logic                         pos_reg [3];
    logic                         pos_c [3];
    logic                         is_load_reg;
    logic                         ground_reg, ground_next;
    logic                         wall_reg, wall_next;
    logic [1:0]                   wdir_reg, wdir_next;

    // Push-out decision
    logic                         hit;
    logic [1:0]                   axis;

    acr_pkg::result_t             result_reg, result_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg  <= acr_pkg::BOX_COUNT_RST;
            kill_floor_reg <= acr_pkg::KILL_FLOOR_Y_RST;
            respawn_reg    <= acr_pkg::RESPAWN_Y_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == acr_pkg::REG_BOX_COUNT)
                box_count_reg <= cfg_data[acr_pkg::COUNT_W-1:0];
            else if (cfg_index == acr_pkg::REG_KILL_FLOOR_Y)
                kill_floor_reg <= $signed(cfg_data);
            else if (cfg_index == acr_pkg::REG_RESPAWN_Y)
                respawn_reg <= $signed(cfg_data);
        end
    end

    assign stat.is_load   = (item.cmd == acr_pkg::CMD_LOAD);
    assign stat.box_count = box_count_reg;

    // Write a loaded box, read the entry the controller points at
    assign slot_ok  = int'(item.box_slot) < MAX_BOXES;
    assign slot_idx = IDX_W'(item.box_slot);

    always_ff @(posedge clk)
    begin
        if (ctl.take && item.cmd == acr_pkg::CMD_LOAD && slot_ok)
            box_mem[slot_idx] <= '{cx: item.pos_x, cy: item.pos_y, cz: item.pos_z,
                                   hx: item.ext_x, hy: item.ext_y, hz: item.ext_z};
        rd_box_reg <= box_mem[rd_addr];
    end

    // Penetration depth per axis: player half + box half - center distance
    always_comb
    begin
        logic signed [CW-1:0] bc [3];
        logic [HW-1:0]        bh [3];
        logic signed [CW:0]   diff;
        logic signed [DW-1:0] sep;
        logic [DW-1:0]        hsum;
        bc[0] = rd_box_reg.cx;
        bc[1] = rd_box_reg.cy;
        bc[2] = rd_box_reg.cz;
        bh[0] = rd_box_reg.hx;
        bh[1] = rd_box_reg.hy;
        bh[2] = rd_box_reg.hz;
        for (int k = 0; k < 3; k++)
        begin
            diff       = (CW+1)'(p_reg[k]) - (CW+1)'(bc[k]);
            pos_c[k]   = diff > 0;
            sep        = pos_c[k] ? DW'(diff) : -DW'(diff);
            hsum       = DW'(h_reg[k]) + DW'(bh[k]);
            depth_c[k] = $signed(hsum) - sep;
        end
    end

    // Least-penetration axis; ties favor x, then y
    always_comb
    begin
        hit  = (depth_reg[0] > 0) && (depth_reg[1] > 0) && (depth_reg[2] > 0);
        axis = 2'd0;
        if (depth_reg[1] < depth_reg[0])
            axis = 2'd1;
        if (depth_reg[2] < ((axis == 2'd1) ? depth_reg[1] : depth_reg[0]))
            axis = 2'd2;
    end

    // Player update on take and on push
    always_comb
    begin
        logic signed [SW-1:0] sum;
        p_next      = p_reg;
        v_next      = v_reg;
        ground_next = ground_reg;
        wall_next   = wall_reg;
        wdir_next   = wdir_reg;
        sum         = '0;
        if (ctl.take)
        begin
            p_next[0]   = item.pos_x;
            p_next[1]   = item.pos_y;
            p_next[2]   = item.pos_z;
            v_next[0]   = item.vel_x;
            v_next[1]   = item.vel_y;
            v_next[2]   = item.vel_z;
            ground_next = 1'b0;
            wall_next   = 1'b0;
            wdir_next   = acr_pkg::WALL_POS_X;
        end
        else if (ctl.push_en && hit)
        begin
            // Move the chosen coordinate away from the box center, saturating
            for (int k = 0; k < 3; k++)
            begin
                if (axis == 2'(k))
                begin
                    if (pos_reg[k])
                        sum = SW'(p_reg[k]) + SW'(depth_reg[k]);
                    else
                        sum = SW'(p_reg[k]) - SW'(depth_reg[k]);
                    if (sum > SW'(acr_pkg::POS_MAX))
                        p_next[k] = acr_pkg::POS_MAX;
                    else if (sum < SW'(acr_pkg::POS_MIN))
                        p_next[k] = acr_pkg::POS_MIN;
                    else
                        p_next[k] = sum[CW-1:0];
                end
            end
            if (axis == 2'd1)
            begin
                // Floor or ceiling contact
                if (pos_reg[1])
                begin
                    ground_next = 1'b1;
                    if (v_reg[1] < 0)
                        v_next[1] = '0;
                end
                else if (v_reg[1] > 0)
                begin
                    v_next[1] = '0;
                end
            end
            else
            begin
                // Wall contact: record the first normal, drop velocity into it
                if (!wall_reg)
                begin
                    wall_next = 1'b1;
                    if (axis == 2'd0)
                        wdir_next = pos_reg[0] ? acr_pkg::WALL_POS_X : acr_pkg::WALL_NEG_X;
                    else
                        wdir_next = pos_reg[2] ? acr_pkg::WALL_POS_Z : acr_pkg::WALL_NEG_Z;
                end
                if (axis == 2'd0 && (pos_reg[0] ? (v_reg[0] < 0) : (v_reg[0] > 0)))
                    v_next[0] = '0;
                if (axis == 2'd2 && (pos_reg[2] ? (v_reg[2] < 0) : (v_reg[2] > 0)))
                    v_next[2] = '0;
            end
        end
    end

    // Player payload registers
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        v_reg <= v_next;
        if (ctl.take)
        begin
            h_reg[0] <= item.ext_x;
            h_reg[1] <= item.ext_y;
            h_reg[2] <= item.ext_z;
        end
        if (ctl.depth_en)
        begin
            depth_reg <= depth_c;
            pos_reg   <= pos_c;
        end
    end

    // Contact flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_load_reg <= 1'b0;
            ground_reg  <= 1'b0;
            wall_reg    <= 1'b0;
            wdir_reg    <= acr_pkg::WALL_POS_X;
        end
        else
        begin
            if (ctl.take)
                is_load_reg <= stat.is_load;
            ground_reg <= ground_next;
            wall_reg   <= wall_next;
            wdir_reg   <= wdir_next;
        end
    end

    // Final result with the kill floor check; loads give all zero
    always_comb
    begin
        logic below;
        below       = p_reg[1] < kill_floor_reg;
        result_next = '0;
        if (!is_load_reg)
        begin
            result_next.res_x     = p_reg[0];
            result_next.res_y     = below ? respawn_reg : p_reg[1];
            result_next.res_z     = p_reg[2];
            result_next.new_vel_x = below ? '0 : v_reg[0];
            result_next.new_vel_y = below ? '0 : v_reg[1];
            result_next.new_vel_z = below ? '0 : v_reg[2];
            result_next.on_ground = ground_reg || below;
            result_next.on_wall   = wall_reg;
            result_next.wall_dir  = wdir_reg;
            result_next.respawned = below;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
            result_reg <= result_next;
    end

    assign result = result_reg;

`ifndef SYNTHESIS
    a_wall_dir_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !wall_reg |-> wdir_reg == acr_pkg::WALL_POS_X)
        else $error("wall normal set without a wall contact");
`endif

endmodule

[rtl/aabb_collision_resolver_top.sv]
// Top level of the box collision resolver: channels, config port,
// controller and datapath. Depends on acr_pkg, acr_if, acr_ctrl and acr_dp.

// Load items write one world box to the table and offer an all-zero result.
// A resolve item sweeps PASSES times over the first min(box_count, MAX_BOXES)
// boxes; the sweep is a single depth/push unit that steps through a depth
// state (register the three penetration depths) and a push state (push out)
// for each box, because each push feeds the next box's test. The done state
// loads the result into an output register and returns to idle, where the
// next item can be accepted. The finished result sits in the output
// register, so the next item is accepted while it waits to be taken; a
// second finished result then holds off further input until the first one
// leaves. Table entries read before being loaded give undefined results.
// Write configuration only while the block is idle.
module aabb_collision_resolver_top #(
    parameter int MAX_BOXES = acr_pkg::MAX_BOXES_DEF,
    parameter int PASSES    = acr_pkg::PASSES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [acr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acr_pkg::CFG_DATA_W-1:0]    cfg_data,
    acr_in_if.sink                            in_ch,
    acr_out_if.source                         out_ch
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    acr_pkg::item_t    item;
    acr_pkg::result_t  result;
    acr_pkg::ctl_t     ctl;
    acr_pkg::stat_t    stat;
    logic [IDX_W-1:0]  rd_addr;

    // Gather the input payload
    assign item.cmd      = in_ch.cmd;
    assign item.box_slot = in_ch.box_slot;
    assign item.pos_x    = in_ch.pos_x;
    assign item.pos_y    = in_ch.pos_y;
    assign item.pos_z    = in_ch.pos_z;
    assign item.ext_x    = in_ch.ext_x;
    assign item.ext_y    = in_ch.ext_y;
    assign item.ext_z    = in_ch.ext_z;
    assign item.vel_x    = in_ch.vel_x;
    assign item.vel_y    = in_ch.vel_y;
    assign item.vel_z    = in_ch.vel_z;

    acr_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .PASSES    (PASSES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctl       (ctl),
        .rd_addr   (rd_addr)
    );

    acr_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .stat      (stat),
        .result    (result)
    );

    // Spread the result over the output channel
    assign out_ch.res_x     = result.res_x;
    assign out_ch.res_y     = result.res_y;
    assign out_ch.res_z     = result.res_z;
    assign out_ch.new_vel_x = result.new_vel_x;
    assign out_ch.new_vel_y = result.new_vel_y;
    assign out_ch.new_vel_z = result.new_vel_z;
    assign out_ch.on_ground = result.on_ground;
    assign out_ch.on_wall   = result.on_wall;
    assign out_ch.wall_dir  = result.wall_dir;
    assign out_ch.respawned = result.respawned;

endmodule
